### hw/rtl/stq_pkg.sv
`default_nettype none
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS = 8;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_REMOVE  = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_NONE    = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [30:0]         val;
		logic                flag;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t ent;
	} slot_t;

	typedef struct packed {
		logic                ins;
		logic                del;
		logic                adv;
		logic                sel_ge;
		logic                sel_empty;
		logic                sel_match;
		logic [30:0]         dur;
		logic [30:0]         elapsed;
		logic [TAG_BITS-1:0] tag;
	} cmd_t;

	typedef struct packed {
		logic ge;
		logic tail_le;
	} cell_flags_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  timer_tag;
		logic [30:0] duration_ms;
		logic        defer_next_advance;
		logic        head_fired;
		logic [30:0] elapsed_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        expired_valid;
		logic [7:0]  expired_tag;
		logic        head_valid;
		logic [30:0] next_wait_ms;
		logic [4:0]  entry_count;
	} rsp_t;

endpackage
`default_nettype wire

### hw/rtl/stq_cell.sv
`default_nettype none
module stq_cell
	import stq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire slot_t       left,
	input  wire slot_t       right,
	input  wire logic        passed_in,
	output logic             passed_out,
	output slot_t            cur,
	output slot_t            nxt,
	output cell_flags_t      flags
);

	logic  valid_q;
	entry_t ent_q;
	logic  hit;
	logic  at;
	slot_t moved;

	assign cur.valid = valid_q;
	assign cur.ent = ent_q;

	assign flags.ge = valid_q & (ent_q.val >= cmd.dur);
	assign flags.tail_le = valid_q & ~right.valid & (cmd.dur >= ent_q.val);

	assign hit = (cmd.sel_ge & flags.ge)
		| (cmd.sel_empty & ~valid_q)
		| (cmd.sel_match & valid_q & (ent_q.tag == cmd.tag));
	assign at = passed_in | hit;
	assign passed_out = at;

	always_comb begin
		moved = cur;
		if (at && cmd.ins) begin
			if (passed_in) begin
				moved = left;
			end else begin
				moved.valid = 1'b1;
				moved.ent.val = cmd.dur;
				moved.ent.flag = left.ent.flag;
				moved.ent.tag = cmd.tag;
			end
		end else if (at && cmd.del) begin
			moved = right;
		end
		nxt = moved;
		if (cmd.adv) begin
			if (moved.ent.flag) begin
				nxt.ent.flag = 1'b0;
			end else if (moved.ent.val > cmd.elapsed) begin
				nxt.ent.val = moved.ent.val - cmd.elapsed;
			end else begin
				nxt.ent.val = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= nxt.ent;
	end

endmodule
`default_nettype wire

### hw/rtl/sorted_timeout_queue_unit.sv
// sorted timeout queue: a row of entry cells kept in order of remaining time.
// requests arrive on req (req_valid/req_ready); one response beat per request
// leaves on rsp (rsp_valid/rsp_ready).
// insert places a timer by its duration, remove drops the head-most entry with
// the given tag, advance optionally pops the head as expired and then ages all
// entries by elapsed_ms (flagged entries only lose their flag).
// every request is done in the cycle it is accepted: each cell compares,
// shifts toward its neighbor and ages its entry in parallel, so the response
// beat is registered and valid in the cycle after acceptance.
// throughput is one request per cycle while rsp_ready stays high; the response
// register is the only buffer, so a request is taken while rsp is empty or
// being taken in the same cycle.
// if rsp_ready stays low, the response beat is held and req_ready drops until
// it is taken.
// reset empties the queue (count zero, all cells invalid) and drops any
// pending response beat; no clearing pass is needed.
`default_nettype none
module sorted_timeout_queue_unit
	import stq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	slot_t       slot_cur [QUEUE_DEPTH];
	slot_t       slot_nxt [QUEUE_DEPTH];
	cell_flags_t cell_flags [QUEUE_DEPTH];
	slot_t       left_of [QUEUE_DEPTH];
	slot_t       right_of [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] passed;
	logic [QUEUE_DEPTH-1:0] vld;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	rsp_t       rsp_d;
	cmd_t       cmd;
	status_t    status;

	logic fire, is_ins, is_rem, is_adv, full, empty, ins_ok;
	logic front, back, tail_le_any, pop, found, dropped;

	assign req_ready = ~rsp_valid_q | rsp_ready;
	assign fire = req_valid & req_ready;
	assign is_ins = fire & (req.req_type == REQ_INSERT);
	assign is_rem = fire & (req.req_type == REQ_REMOVE);
	assign is_adv = fire & (req.req_type == REQ_ADVANCE);
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = ~slot_cur[0].valid;
	assign ins_ok = is_ins & ~full;

	always_comb begin
		tail_le_any = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			tail_le_any = tail_le_any | cell_flags[i].tail_le;
			vld[i] = slot_cur[i].valid;
		end
	end

	assign front = ins_ok & (empty | cell_flags[0].ge);
	assign back = ins_ok & ~front & tail_le_any;
	assign pop = is_adv & req.head_fired & ~empty;

	always_comb begin
		cmd.ins = ins_ok;
		cmd.del = is_rem | pop;
		cmd.adv = is_adv;
		cmd.sel_ge = ins_ok & ~front & ~back;
		cmd.sel_empty = back;
		cmd.sel_match = is_rem;
		cmd.dur = req.duration_ms;
		cmd.elapsed = req.elapsed_ms;
		cmd.tag = TAG_BITS'(req.timer_tag);
	end

	assign passed[0] = front | pop;

	// new entry enters cell 0 from the left; other cells get the flag in g_cell below
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (i == 0) begin
				left_of[i].valid = 1'b1;
				left_of[i].ent.val = req.duration_ms;
				left_of[i].ent.flag = req.defer_next_advance;
				left_of[i].ent.tag = TAG_BITS'(req.timer_tag);
			end else begin
				left_of[i] = slot_cur[i-1];
			end
			if (i == QUEUE_DEPTH - 1) begin
				right_of[i] = '0;
			end else begin
				right_of[i] = slot_cur[i+1];
			end
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		slot_t left_g;
		always_comb begin
			left_g = left_of[g];
			if (g != 0) begin
				if (!passed[g]) begin
					left_g.ent.flag = req.defer_next_advance;
				end
			end
		end
		stq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left       (left_g),
			.right      (right_of[g]),
			.passed_in  (passed[g]),
			.passed_out (passed[g+1]),
			.cur        (slot_cur[g]),
			.nxt        (slot_nxt[g]),
			.flags      (cell_flags[g])
		);
	end

	assign found = passed[QUEUE_DEPTH];
	assign dropped = (is_rem & found) | pop;
	assign count_d = count_q + CNT_W'(ins_ok) - CNT_W'(dropped);

	always_comb begin
		status = ST_OK;
		if (is_ins && full) begin
			status = ST_FULL;
		end else if (is_rem && !found) begin
			status = ST_NOT_FOUND;
		end else if (is_adv && req.head_fired && empty) begin
			status = ST_EMPTY;
		end
		rsp_d.status = status;
		rsp_d.expired_valid = pop;
		rsp_d.expired_tag = pop ? 8'(slot_cur[0].ent.tag) : 8'd0;
		rsp_d.head_valid = slot_nxt[0].valid;
		rsp_d.next_wait_ms = slot_nxt[0].valid ? slot_nxt[0].ent.val : 31'd0;
		rsp_d.entry_count = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(vld)))
		else $error("entry count differs from occupied cells");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((vld + QUEUE_DEPTH'(1)) & vld) == '0)
		else $error("occupied cells are not packed at the head");

	a_full_insert_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(is_ins && full) |=> $stable(count_q))
		else $error("insert into full queue changed the count");

	a_pop_reports: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (rsp_valid && rsp.expired_valid && rsp.status == ST_OK))
		else $error("popped head not reported");

endmodule
`default_nettype wire
